// File: rtl/fsla_pkg.sv
// Package for the fixed-slot free-list allocator.
// Holds sizes, codes and the transaction and configuration struct types.
// No dependencies.
package fsla_pkg;

	localparam int MAX_SLOTS = 1024;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int CNT_W     = SLOT_W + 1;
	localparam int ADDR_W    = 32;
	localparam int HDR_W     = 12;
	localparam int SIZE_W    = 16;
	localparam int PROD_W    = SIZE_W + SLOT_W;
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;

	// Opcodes of a request.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Result status codes.
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_EMPTY  = 2'd1;
	localparam logic [1:0] STAT_RANGE  = 2'd2;
	localparam logic [1:0] STAT_DOUBLE = 2'd3;

	// Register indexes (byte address divided by four).
	localparam logic [1:0] REG_BASE   = 2'd0;
	localparam logic [1:0] REG_HEADER = 2'd1;
	localparam logic [1:0] REG_SIZE   = 2'd2;
	localparam logic [1:0] REG_COUNT  = 2'd3;

	// Register reset values.
	localparam logic [ADDR_W-1:0] RST_BASE   = '0;
	localparam logic [HDR_W-1:0]  RST_HEADER = '0;
	localparam logic [SIZE_W-1:0] RST_SIZE   = SIZE_W'(64);
	localparam logic [CNT_W-1:0]  RST_COUNT  = CNT_W'(MAX_SLOTS);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_READY,
		ST_LOOKUP
	} st_t;

	typedef struct packed {
		logic              opcode;
		logic [SLOT_W-1:0] slot_index;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] granted_index;
		logic [ADDR_W-1:0] slot_address;
		logic [CNT_W-1:0]  free_count;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0] base_address;
		logic [HDR_W-1:0]  header_bytes;
		logic [SIZE_W-1:0] object_size;
		logic [CNT_W-1:0]  slot_count;
	} cfg_t;

endpackage

// File: rtl/fixed_slot_free_list_allocator.sv
// Top level of the fixed-slot free-list allocator: control, free ring and in-use map.
// Depends on fsla_pkg, fsla_regs and fsla_addr.
//
//   Channel    Signals                                 Transaction completes when
//   ---------  --------------------------------------  ---------------------------------
//   request    start, busy, req (opcode, slot_index)   start high and busy low at clk
//   result     done, rsp (status, index, addr, count)  done high at clk (one cycle only)
//   config     psel, penable, pwrite, paddr, pwdata    psel, penable, pwrite, pready high
//
// A request is accepted in the ready state, which issues the synchronous read of the
// free ring and in-use map, and decided in the lookup state, which writes them back;
// busy is high in the lookup state, so a new transaction can start only once the block
// is back in ready. The result strobe done follows the lookup through the second-stage
// and result registers. After reset and every configuration write, a clearing pass
// rewrites the ring in ascending order and clears the map; busy stays high meanwhile.
// The receiver cannot stall: every result is shown for exactly one cycle.
module fixed_slot_free_list_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  fsla_pkg::req_t                req,
	output logic                          done,
	output fsla_pkg::rsp_t                rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fsla_pkg::PADDR_W-1:0]  paddr,
	input  logic [fsla_pkg::PDATA_W-1:0]  pwdata,
	output logic [fsla_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import fsla_pkg::*;

	// Configuration.
	cfg_t cfg;
	cfg_t cfg_next;
	logic cfg_wr;

	// Control state.
	st_t               state_q;
	st_t               state_d;
	logic              clearing;
	logic              lookup;
	logic              accept;
	logic [SLOT_W-1:0] clr_q;
	logic [SLOT_W-1:0] head_q;
	logic [SLOT_W-1:0] tail_q;
	logic [CNT_W-1:0]  free_q;
	logic [CNT_W-1:0]  free_after;

	// The free ring holds slot indexes; the in-use map holds one bit per slot.
	logic [SLOT_W-1:0] ring_mem [MAX_SLOTS];
	logic              map_mem  [MAX_SLOTS];
	logic [SLOT_W-1:0] ring_rd_q;
	logic              map_rd_q;
	logic              ring_we;
	logic [SLOT_W-1:0] ring_waddr;
	logic [SLOT_W-1:0] ring_wdata;
	logic              map_we;
	logic [SLOT_W-1:0] map_waddr;
	logic              map_wdata;

	// Request held during the lookup cycle.
	req_t req_s1;

	// Outcome of the lookup.
	logic              alloc_ok;
	logic              free_ok;
	logic [1:0]        status_d;
	logic [SLOT_W-1:0] granted_d;

	// Second stage and the result register.
	logic              valid_s2;
	logic [1:0]        status_s2;
	logic [SLOT_W-1:0] granted_s2;
	logic [CNT_W-1:0]  free_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic              done_q;
	rsp_t              rsp_q;

	fsla_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.wr       (cfg_wr),
		.cfg      (cfg),
		.cfg_next (cfg_next)
	);

	assign pready = 1'b1;

	// Next state. A configuration write always restarts the clearing pass.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == SLOT_W'(MAX_SLOTS - 1)) begin
					state_d = ST_READY;
				end
			end
			ST_READY: begin
				if (start) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				state_d = ST_READY;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
		if (cfg_wr) begin
			state_d = ST_CLEAR;
		end
	end

	// State decode.
	always_comb begin
		busy     = 1'b1;
		clearing = 1'b0;
		lookup   = 1'b0;
		case (state_q)
			ST_CLEAR:  clearing = 1'b1;
			ST_READY:  busy     = 1'b0;
			ST_LOOKUP: lookup   = 1'b1;
			default:   busy     = 1'b1;
		endcase
	end

	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	// Decide the request. The map read was issued with the slot index at acceptance,
	// the ring read with the head pointer, which does not move until this cycle ends.
	always_comb begin
		alloc_ok  = 1'b0;
		free_ok   = 1'b0;
		status_d  = STAT_OK;
		granted_d = '0;
		if (req_s1.opcode == OP_ALLOC) begin
			if (free_q == '0) begin
				status_d = STAT_EMPTY;
			end else begin
				alloc_ok  = lookup;
				granted_d = ring_rd_q;
			end
		end else begin
			if ({1'b0, req_s1.slot_index} >= cfg.slot_count) begin
				status_d = STAT_RANGE;
			end else if (!map_rd_q) begin
				status_d = STAT_DOUBLE;
			end else begin
				free_ok = lookup;
			end
		end
	end

	always_comb begin
		free_after = free_q;
		if (alloc_ok) begin
			free_after = free_q - CNT_W'(1);
		end else if (free_ok) begin
			free_after = free_q + CNT_W'(1);
		end
	end

	// Ring write port: the clearing pass writes entry i with i, a free appends at the tail.
	always_comb begin
		ring_we    = 1'b0;
		ring_waddr = tail_q;
		ring_wdata = req_s1.slot_index;
		if (clearing) begin
			ring_we    = 1'b1;
			ring_waddr = clr_q;
			ring_wdata = clr_q;
		end else if (free_ok) begin
			ring_we = 1'b1;
		end
	end

	// Map write port: clearing, marking an allocated slot, or releasing a freed one.
	always_comb begin
		map_we    = 1'b0;
		map_waddr = req_s1.slot_index;
		map_wdata = 1'b0;
		if (clearing) begin
			map_we    = 1'b1;
			map_waddr = clr_q;
		end else if (alloc_ok) begin
			map_we    = 1'b1;
			map_waddr = ring_rd_q;
			map_wdata = 1'b1;
		end else if (free_ok) begin
			map_we = 1'b1;
		end
	end

	// Both memories are written in the lookup cycle and read again no earlier than
	// the next accepted request, so no forwarding path is needed.
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_waddr] <= ring_wdata;
		end
		ring_rd_q <= ring_mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_waddr] <= map_wdata;
		end
		map_rd_q <= map_mem[req.slot_index];
	end

	// Pointers and the free count. A configuration write rebuilds the list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			head_q <= '0;
			tail_q <= RST_COUNT[SLOT_W-1:0];
			free_q <= RST_COUNT;
		end else if (cfg_wr) begin
			clr_q  <= '0;
			head_q <= '0;
			tail_q <= cfg_next.slot_count[SLOT_W-1:0];
			free_q <= cfg_next.slot_count;
		end else begin
			if (clearing) begin
				clr_q <= clr_q + SLOT_W'(1);
			end
			if (alloc_ok) begin
				head_q <= head_q + SLOT_W'(1);
			end
			if (free_ok) begin
				tail_q <= tail_q + SLOT_W'(1);
			end
			free_q <= free_after;
		end
	end

	fsla_addr u_addr (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (alloc_ok),
		.object_size  (cfg.object_size),
		.slot_index   (ring_rd_q),
		.base_address (cfg.base_address),
		.header_bytes (cfg.header_bytes),
		.slot_address (addr_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s2 <= lookup;
			done_q   <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (lookup) begin
			status_s2  <= status_d;
			granted_s2 <= granted_d;
			free_s2    <= free_after;
		end
		if (valid_s2) begin
			rsp_q.status        <= status_s2;
			rsp_q.granted_index <= granted_s2;
			rsp_q.slot_address  <= addr_s2;
			rsp_q.free_count    <= free_s2;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// A result strobe always follows a second-stage transaction.
	a_done_follows_s2: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(valid_s2))
		else $error("result strobe without a transaction in the second stage");

	// The second stage is only loaded from a lookup cycle.
	a_s2_from_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $past(state_q == ST_LOOKUP))
		else $error("second stage loaded without a lookup");

	// No request may be taken while the memories are being cleared.
	a_busy_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> busy)
		else $error("request port open during the clearing pass");

	// The free count never exceeds the configured slot count.
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READY) |-> (free_q <= cfg.slot_count))
		else $error("free count above slot count");

endmodule

// File: rtl/fsla_regs.sv
// Configuration register file behind the APB-style port.
// Depends on fsla_pkg for the register indexes, widths and cfg_t.
module fsla_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fsla_pkg::PADDR_W-1:0]  paddr,
	input  logic [fsla_pkg::PDATA_W-1:0]  pwdata,
	output logic [fsla_pkg::PDATA_W-1:0]  prdata,
	output logic                          wr,
	output fsla_pkg::cfg_t                cfg,
	output fsla_pkg::cfg_t                cfg_next
);
	import fsla_pkg::*;

	cfg_t             cfg_q;
	logic [CNT_W-1:0] count_raw;
	logic [CNT_W-1:0] count_sat;

	assign wr = psel & penable & pwrite;

	// A slot count of zero is taken as one, anything above the maximum saturates.
	assign count_raw = pwdata[CNT_W-1:0];
	always_comb begin
		count_sat = count_raw;
		if (count_raw == '0) begin
			count_sat = CNT_W'(1);
		end else if (count_raw > CNT_W'(MAX_SLOTS)) begin
			count_sat = CNT_W'(MAX_SLOTS);
		end
	end

	always_comb begin
		cfg_next = cfg_q;
		if (wr) begin
			case (paddr[3:2])
				REG_BASE:   cfg_next.base_address = pwdata[ADDR_W-1:0];
				REG_HEADER: cfg_next.header_bytes = pwdata[HDR_W-1:0];
				REG_SIZE:   cfg_next.object_size  = pwdata[SIZE_W-1:0];
				REG_COUNT:  cfg_next.slot_count   = count_sat;
				default:    cfg_next = cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_address <= RST_BASE;
			cfg_q.header_bytes <= RST_HEADER;
			cfg_q.object_size  <= RST_SIZE;
			cfg_q.slot_count   <= RST_COUNT;
		end else begin
			cfg_q <= cfg_next;
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_BASE:   prdata = PDATA_W'(cfg_q.base_address);
			REG_HEADER: prdata = PDATA_W'(cfg_q.header_bytes);
			REG_SIZE:   prdata = PDATA_W'(cfg_q.object_size);
			REG_COUNT:  prdata = PDATA_W'(cfg_q.slot_count);
			default:    prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/fsla_addr.sv
// Slot address unit: registered size-times-index product, then base plus header plus product.
// Depends on fsla_pkg for the field widths.
module fsla_addr (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [fsla_pkg::SIZE_W-1:0]   object_size,
	input  logic [fsla_pkg::SLOT_W-1:0]   slot_index,
	input  logic [fsla_pkg::ADDR_W-1:0]   base_address,
	input  logic [fsla_pkg::HDR_W-1:0]    header_bytes,
	output logic [fsla_pkg::ADDR_W-1:0]   slot_address
);
	import fsla_pkg::*;

	logic [PROD_W-1:0] prod_s2;
	logic              grant_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grant_s2 <= 1'b0;
		end else begin
			grant_s2 <= en;
		end
	end

	// Both operands are widened first so that the full product is kept.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= PROD_W'(object_size) * PROD_W'(slot_index);
		end
	end

	// The sum wraps modulo 2^32; any request but a granted allocation reports address zero.
	assign slot_address = grant_s2
		? base_address + ADDR_W'(header_bytes) + ADDR_W'(prod_s2)
		: '0;

endmodule

// File: tb/tb_fixed_slot_free_list_allocator.sv
// Self-checking testbench for the fixed-slot free-list allocator.
// Depends on fsla_pkg and fixed_slot_free_list_allocator; mirrors the free list to check replies.
`timescale 1ns / 1ps

module tb_fixed_slot_free_list_allocator;

	import fsla_pkg::*;

	// Mirror of the allocator: its own copy of the registers, the free ring, the pointers and
	// the in-use map. Every accepted request is applied here at once and the reply it must
	// produce is queued; every reply strobed by the block is compared with the oldest one.
	class free_list_mirror;
		cfg_t              cfg;
		logic [SLOT_W-1:0] ring [MAX_SLOTS];
		logic [SLOT_W-1:0] head;
		logic [SLOT_W-1:0] tail;
		logic [CNT_W-1:0]  free_total;
		bit                in_use [MAX_SLOTS];
		rsp_t              replies_due [$];
		int                failures;

		function new();
			cfg.base_address = RST_BASE;
			cfg.header_bytes = RST_HEADER;
			cfg.object_size  = RST_SIZE;
			cfg.slot_count   = RST_COUNT;
			failures = 0;
			rebuild();
		endfunction

		// The block lays the ring out in ascending order after reset and after any write.
		function void rebuild();
			for (int i = 0; i < MAX_SLOTS; i++) begin
				ring[i] = SLOT_W'(i);
				in_use[i] = 1'b0;
			end
			head = '0;
			tail = SLOT_W'(cfg.slot_count % MAX_SLOTS);
			free_total = cfg.slot_count;
		endfunction

		function void write_register(logic [1:0] which, logic [PDATA_W-1:0] value);
			logic [CNT_W-1:0] count;
			case (which)
				REG_BASE: begin
					cfg.base_address = value[ADDR_W-1:0];
				end
				REG_HEADER: begin
					cfg.header_bytes = value[HDR_W-1:0];
				end
				REG_SIZE: begin
					cfg.object_size = value[SIZE_W-1:0];
				end
				default: begin
					// A count of zero is taken as one; anything above the ring depth saturates.
					count = value[CNT_W-1:0];
					if (count == '0)
						count = CNT_W'(1);
					if (count > CNT_W'(MAX_SLOTS))
						count = CNT_W'(MAX_SLOTS);
					cfg.slot_count = count;
				end
			endcase
			rebuild();
		endfunction

		function void note_request(req_t item);
			rsp_t              reply;
			logic [SLOT_W-1:0] slot;
			logic [63:0]       addr_sum;
			reply = '0;
			reply.status = STAT_OK;
			if (item.opcode == OP_ALLOC) begin
				if (free_total == '0) begin
					reply.status = STAT_EMPTY;
				end else begin
					slot = ring[head];
					head = (head == SLOT_W'(MAX_SLOTS - 1)) ? '0 : head + 1'b1;
					free_total = free_total - 1'b1;
					in_use[slot] = 1'b1;
					reply.granted_index = slot;
					addr_sum = 64'(cfg.base_address) + 64'(cfg.header_bytes)
						+ 64'(cfg.object_size) * 64'(slot);
					reply.slot_address = addr_sum[ADDR_W-1:0];
				end
			end else if (CNT_W'(item.slot_index) >= cfg.slot_count) begin
				reply.status = STAT_RANGE;
			end else if (!in_use[item.slot_index]) begin
				reply.status = STAT_DOUBLE;
			end else begin
				ring[tail] = item.slot_index;
				tail = (tail == SLOT_W'(MAX_SLOTS - 1)) ? '0 : tail + 1'b1;
				free_total = free_total + 1'b1;
				in_use[item.slot_index] = 1'b0;
			end
			reply.free_count = free_total;
			replies_due.push_back(reply);
		endfunction

		function void check_reply(rsp_t got);
			rsp_t want;
			if (replies_due.size() == 0) begin
				if (failures < 10)
					$display("reply with nothing outstanding: status %0d index %0d addr %h count %0d",
						got.status, got.granted_index, got.slot_address, got.free_count);
				failures++;
				return;
			end
			want = replies_due.pop_front();
			if (got.status !== want.status || got.granted_index !== want.granted_index ||
					got.slot_address !== want.slot_address ||
					got.free_count !== want.free_count) begin
				if (failures < 10)
					$display("reply mismatch: want status %0d index %0d addr %h count %0d, %s",
						want.status, want.granted_index, want.slot_address, want.free_count,
						$sformatf("got status %0d index %0d addr %h count %0d", got.status,
						got.granted_index, got.slot_address, got.free_count));
				failures++;
			end
		endfunction

		function int outstanding();
			return replies_due.size();
		endfunction

		// Any slot that is currently handed out, searched from a random point; -1 if none.
		function int pick_allocated_slot();
			int first;
			int slot;
			first = $urandom_range(MAX_SLOTS - 1);
			for (int k = 0; k < MAX_SLOTS; k++) begin
				slot = (first + k) % MAX_SLOTS;
				if (in_use[slot])
					return slot;
			end
			return -1;
		endfunction
	endclass

	// All inputs of the block hold known values from time zero on.
	logic                clk     = 1'b0;
	logic                arst_n  = 1'b0;
	logic                start   = 1'b0;
	req_t                req     = '0;
	logic                psel    = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite  = 1'b0;
	logic [PADDR_W-1:0]  paddr   = '0;
	logic [PDATA_W-1:0]  pwdata  = '0;
	logic                busy;
	logic                done;
	rsp_t                rsp;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	free_list_mirror mirror;
	bit              gaps_on;
	int              last_freed;

	fixed_slot_free_list_allocator u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// The run is cut off well past the slowest legal run, in case the block hangs.
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// A reply is valid on rsp in the one cycle that done marks, so it is taken at that edge.
	// Values read here are the ones from before the edge, whatever order the processes run in.
	always @(posedge clk) begin
		if (arst_n && done)
			mirror.check_reply(rsp);
	end

	function automatic req_t make_request(logic op, int slot);
		req_t item;
		item.opcode = op;
		item.slot_index = SLOT_W'(slot);
		return item;
	endfunction

	// Presents one request and holds it until the block takes it. The transaction completes
	// at the edge where start is high and busy was low. When gaps are enabled, start drops
	// now and then, so that the next request lands on varying phases of the ready and lookup
	// states of the request path.
	task automatic send_request(req_t item);
		if (gaps_on && $urandom_range(99) < 14) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start <= 1'b1;
		req <= item;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		mirror.note_request(item);
	endtask

	// Stops issuing and waits until every reply that is owed has come back. Every request
	// produces a reply, so the block is idle once none is outstanding.
	task automatic drain_replies();
		start <= 1'b0;
		do
			@(posedge clk);
		while (mirror.outstanding() != 0);
	endtask

	// One APB write: setup cycle, then access until pready, then the bus goes idle. The block
	// starts its clearing pass afterwards and keeps busy high while it runs.
	task automatic write_register(logic [1:0] which, logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({which, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		forever begin
			@(posedge clk);
			if (pready)
				break;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		mirror.write_register(which, value);
		@(posedge clk);
	endtask

	// One random phase under a fresh configuration. Most traffic is well formed: allocations
	// and frees of slots that are really handed out. About a tenth is noise with any opcode and
	// index, and a few frees repeat the slot freed last, which normally is a double free.
	// Half way through, the sender holds back until all replies are in.
	task automatic run_phase(logic [31:0] base, logic [31:0] header, logic [31:0] size,
			logic [31:0] count, int n_items, int alloc_pct);
		int   slot;
		req_t item;
		drain_replies();
		write_register(REG_BASE, base);
		write_register(REG_HEADER, header);
		write_register(REG_SIZE, size);
		write_register(REG_COUNT, count);
		for (int n = 0; n < n_items; n++) begin
			if (n == n_items / 2)
				drain_replies();
			if ($urandom_range(99) < 10) begin
				item = make_request(1'($urandom_range(1)), $urandom_range(MAX_SLOTS - 1));
			end else if ($urandom_range(99) < 4 && last_freed >= 0) begin
				item = make_request(OP_FREE, last_freed);
			end else if ($urandom_range(99) < alloc_pct) begin
				item = make_request(OP_ALLOC, $urandom_range(MAX_SLOTS - 1));
			end else begin
				slot = mirror.pick_allocated_slot();
				if (slot < 0) begin
					item = make_request(OP_ALLOC, $urandom_range(MAX_SLOTS - 1));
				end else begin
					item = make_request(OP_FREE, slot);
					last_freed = slot;
				end
			end
			send_request(item);
		end
	endtask

	initial begin
		mirror = new();
		gaps_on = 1'b0;
		last_freed = -1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset configuration: the first grant, a free of a slot that
		// was never handed out, a good free and the next grant in line.
		send_request(make_request(OP_ALLOC, 0));
		send_request(make_request(OP_FREE, MAX_SLOTS - 1));
		send_request(make_request(OP_FREE, 0));
		send_request(make_request(OP_ALLOC, MAX_SLOTS - 1));

		// Three slots at the top of the address space with the largest header and size, so
		// that the slot address wraps. Drains the list, then hits every error status.
		drain_replies();
		write_register(REG_BASE, 32'hFFFF_FFF0);
		write_register(REG_HEADER, 32'h0000_0FFF);
		write_register(REG_SIZE, 32'h0000_FFFF);
		write_register(REG_COUNT, 32'd3);
		repeat (3) send_request(make_request(OP_ALLOC, 0));
		send_request(make_request(OP_ALLOC, 0));
		send_request(make_request(OP_FREE, 3));
		send_request(make_request(OP_FREE, MAX_SLOTS - 1));
		send_request(make_request(OP_FREE, 1));
		send_request(make_request(OP_FREE, 1));
		send_request(make_request(OP_ALLOC, 0));
		send_request(make_request(OP_FREE, 0));
		send_request(make_request(OP_FREE, 2));

		// A slot count of zero means one slot, and a zero object size puts every slot at
		// base plus header.
		drain_replies();
		write_register(REG_SIZE, 32'd0);
		write_register(REG_COUNT, 32'd0);
		send_request(make_request(OP_ALLOC, 0));
		send_request(make_request(OP_ALLOC, 0));
		send_request(make_request(OP_FREE, 1));
		send_request(make_request(OP_FREE, 0));
		send_request(make_request(OP_FREE, 0));

		// A count above the ring depth saturates, so the top index is in range again.
		drain_replies();
		write_register(REG_COUNT, 32'h0000_07FF);
		send_request(make_request(OP_ALLOC, 0));
		send_request(make_request(OP_FREE, MAX_SLOTS - 1));

		// Random part. The allocation-heavy phase at the extremes runs without gaps.
		gaps_on = 1'b1;
		run_phase($urandom, $urandom_range(4095), $urandom_range(1, 65535),
			$urandom_range(2, 64), 300, 50);
		run_phase($urandom, $urandom_range(4095), 32'd0, 32'd0, 150, 50);
		gaps_on = 1'b0;
		run_phase(32'hFFFF_FFFF, 32'h0000_0FFF, 32'h0000_FFFF, 32'h0000_07FF, 600, 85);
		gaps_on = 1'b1;
		run_phase($urandom, $urandom_range(4095), $urandom_range(1, 65535),
			$urandom_range(1, MAX_SLOTS), 300, 40);
		run_phase(32'd0, 32'd0, 32'd1, 32'd1024, 550, 50);

		// Let the last replies arrive, bounded, then keep the clock running so that the pipeline
		// can show any stray strobe.
		start <= 1'b0;
		for (int n = 0; n < 2000 && mirror.outstanding() != 0; n++)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mirror.outstanding() != 0) begin
			$display("%0d replies never arrived", mirror.outstanding());
			mirror.failures++;
		end

		if (mirror.failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/fsla_pkg.sv
rtl/fsla_regs.sv
rtl/fsla_addr.sv
rtl/fixed_slot_free_list_allocator.sv
tb/tb_fixed_slot_free_list_allocator.sv
